[rtl/pdc_pkg.sv]
// Shared types and constants for the pattern deduplication counter.
// Used by the core and the matcher under rtl; depends on nothing else.
package pdc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_PATTERNS_DEF = 256;
  localparam int MAX_SIDE_DEF     = 4;
  localparam int LEAF_BITS_DEF    = 32;

  // Fixed field widths of the ports.
  localparam int LEAF_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SIDE_W   = 3;

  // Side length after reset.
  localparam logic [SIDE_W-1:0] SIDE_RESET = 3'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LENGTH = 2'd2;

  // One input leaf transfer.
  typedef struct packed {
    logic [LEAF_W-1:0] leaf;
    logic              last_leaf;
  } leaf_item_t;

  // One result transfer.
  typedef struct packed {
    logic [INDEX_W-1:0]  pattern_index;
    logic                is_new;
    logic [COUNT_W-1:0]  occurrences;
    logic [STATUS_W-1:0] status;
  } result_item_t;

  // Outcome of a table search, valid for the single cycle in which done is high.
  typedef struct packed {
    logic done;
    logic hit;
  } match_stat_t;

endpackage

[rtl/pattern_dedup_counter_core.sv]
// Leaves transfer one per cycle while the core is idle; after the last leaf the
// table walk compares stored entries leaf by leaf, moving on at a mismatch; a hit
// then reads and rewrites its count, while an append copies the pattern into the store.
// One pattern at a time: leaves stall from the last leaf until the result register is loaded.
// Reset is synchronous: the table empties by clearing its entry count.
module pattern_dedup_counter_core #(
  parameter int MAX_PATTERNS = pdc_pkg::MAX_PATTERNS_DEF,
  parameter int MAX_SIDE     = pdc_pkg::MAX_SIDE_DEF,
  parameter int LEAF_BITS    = pdc_pkg::LEAF_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [pdc_pkg::SIDE_W-1:0] cfg_data,
  input  logic                     leaf_valid,
  output logic                     leaf_stall,
  input  pdc_pkg::leaf_item_t      leaf_data,
  output logic                     result_valid,
  input  logic                     result_stall,
  output pdc_pkg::result_item_t    result_data
);
  import pdc_pkg::*;

  localparam int LEAVES_MAX  = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W       = $clog2(LEAVES_MAX);
  localparam int LEAF_CNT_W  = $clog2(LEAVES_MAX + 2);
  localparam int ENT_W       = $clog2(MAX_PATTERNS);
  localparam int STORE_DEPTH = MAX_PATTERNS * (1 << IDX_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CNT_RD,
    S_CNT_WR,
    S_COPY,
    S_DONE
  } state_t;

  state_t state;

  logic [SIDE_W-1:0]     side_length;
  logic [LEAF_BITS-1:0]  incoming [LEAVES_MAX];
  logic [LEAF_CNT_W-1:0] leaves_received;
  logic [ENT_W:0]        in_use;
  logic [ENT_W:0]        ent;
  logic [IDX_W-1:0]      copy_idx;
  result_item_t          pend_res;

  // Derived values.
  logic [3:0]            side_eff;
  logic [7:0]            need_full;
  logic [LEAF_CNT_W-1:0] need;
  logic [LEAF_CNT_W-1:0] count_after;
  logic                  leaf_xfer;
  logic                  copy_last;
  logic [IDX_W-1:0]      buf_idx;
  logic [LEAF_BITS-1:0]  buf_leaf;
  logic [COUNT_W-1:0]    cnt_inc;

  // Store and count RAM ports.
  logic                    st_wr_en;
  logic [ENT_W+IDX_W-1:0]  st_wr_addr;
  logic [ENT_W+IDX_W-1:0]  st_rd_addr;
  logic [LEAF_BITS-1:0]    st_rd_data;
  logic                    ct_wr_en;
  logic [COUNT_W-1:0]      ct_wr_data;
  logic [COUNT_W-1:0]      ct_rd_data;

  // Search engine handshake.
  logic                 m_start;
  logic [IDX_W-1:0]     m_ref_idx;
  match_stat_t          m_stat;
  logic [ENT_W-1:0]     m_hit_ent;

  assign cfg_ready  = 1'b1;
  assign leaf_stall = (state != S_IDLE);
  assign leaf_xfer  = leaf_valid && !leaf_stall;

  // Side clamp and leaf count bookkeeping.
  always_comb begin
    side_eff = {1'b0, side_length};
    if (side_eff < 4'd2) begin
      side_eff = 4'd2;
    end else if (side_eff > 4'(MAX_SIDE)) begin
      side_eff = 4'(MAX_SIDE);
    end
    need_full = {4'b0, side_eff} * {4'b0, side_eff};
    need      = LEAF_CNT_W'(need_full);
    if (leaves_received < LEAF_CNT_W'(LEAVES_MAX + 1)) begin
      count_after = leaves_received + LEAF_CNT_W'(1);
    end else begin
      count_after = leaves_received;
    end
  end

  // Incoming buffer read, shared by the search and the append copy.
  always_comb begin
    copy_last = (LEAF_CNT_W'(copy_idx) == (need - LEAF_CNT_W'(1)));
    buf_idx   = (state == S_COPY) ? copy_idx : m_ref_idx;
    buf_leaf  = incoming[buf_idx];
    cnt_inc   = (ct_rd_data == '1) ? ct_rd_data : ct_rd_data + COUNT_W'(1);
  end

  // RAM control.
  always_comb begin
    st_wr_en   = (state == S_COPY);
    st_wr_addr = {ent[ENT_W-1:0], copy_idx};
    ct_wr_en   = (state == S_CNT_WR) || ((state == S_COPY) && copy_last);
    ct_wr_data = (state == S_COPY) ? COUNT_W'(1) : cnt_inc;
    m_start    = leaf_xfer && leaf_data.last_leaf && (count_after == need);
  end

  pdc_ram #(
    .WIDTH (LEAF_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (buf_leaf),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  pdc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_PATTERNS)
  ) u_counts (
    .clk     (clk),
    .wr_en   (ct_wr_en),
    .wr_addr (ent[ENT_W-1:0]),
    .wr_data (ct_wr_data),
    .rd_addr (ent[ENT_W-1:0]),
    .rd_data (ct_rd_data)
  );

  pdc_matcher #(
    .ENT_W      (ENT_W),
    .IDX_W      (IDX_W),
    .LEAF_CNT_W (LEAF_CNT_W),
    .LEAF_BITS  (LEAF_BITS)
  ) u_matcher (
    .clk      (clk),
    .rst      (rst),
    .start    (m_start),
    .need     (need),
    .in_use   (in_use),
    .rd_leaf  (st_rd_data),
    .ref_leaf (buf_leaf),
    .rd_addr  (st_rd_addr),
    .ref_idx  (m_ref_idx),
    .stat     (m_stat),
    .hit_ent  (m_hit_ent)
  );

  // Sequencer, configuration register, incoming buffer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      side_length     <= SIDE_RESET;
      leaves_received <= '0;
      in_use          <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        side_length <= cfg_data;
      end
      // The hand-off state reloads the result register itself.
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (leaf_xfer) begin
            if (leaves_received < LEAF_CNT_W'(LEAVES_MAX)) begin
              incoming[leaves_received[IDX_W-1:0]] <=
                LEAF_BITS'(leaf_data.leaf);
            end
            if (leaf_data.last_leaf) begin
              leaves_received <= '0;
              if (count_after != need) begin
                pend_res <= '{pattern_index: '0, is_new: 1'b0,
                              occurrences: '0, status: ST_LENGTH};
                state    <= S_DONE;
              end else begin
                state <= S_SEARCH;
              end
            end else begin
              leaves_received <= count_after;
            end
          end
        end
        S_SEARCH: begin
          if (m_stat.done) begin
            if (m_stat.hit) begin
              ent   <= {1'b0, m_hit_ent};
              state <= S_CNT_RD;
            end else if (in_use == (ENT_W+1)'(MAX_PATTERNS)) begin
              pend_res <= '{pattern_index: '0, is_new: 1'b0,
                            occurrences: '0, status: ST_FULL};
              state    <= S_DONE;
            end else begin
              ent      <= in_use;
              copy_idx <= '0;
              state    <= S_COPY;
            end
          end
        end
        S_CNT_RD: begin
          state <= S_CNT_WR;
        end
        S_CNT_WR: begin
          pend_res <= '{pattern_index: INDEX_W'(ent), is_new: 1'b0,
                        occurrences: cnt_inc, status: ST_OK};
          state    <= S_DONE;
        end
        S_COPY: begin
          if (copy_last) begin
            in_use   <= in_use + (ENT_W+1)'(1);
            pend_res <= '{pattern_index: INDEX_W'(ent), is_new: 1'b1,
                          occurrences: COUNT_W'(1), status: ST_OK};
            state    <= S_DONE;
          end else begin
            copy_idx <= copy_idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_data  <= pend_res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more entries than it has rows.
  a_in_use_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= (ENT_W+1)'(MAX_PATTERNS))
    else $error("pattern table count exceeds capacity");

  // The search engine only reports while the sequencer waits for it.
  a_done_in_search: assert property (@(posedge clk) disable iff (rst)
    m_stat.done |-> (state == S_SEARCH))
    else $error("search completion outside of search state");

  // A new result only appears out of the result hand-off state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_DONE))
    else $error("result raised without a pending result");

  // Appending a pattern grows the table by exactly one entry.
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    ((state == S_COPY) && copy_last) |=> (in_use == $past(in_use) + (ENT_W+1)'(1)))
    else $error("append did not advance the entry count");

endmodule

[rtl/pdc_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; has no package dependency.
module pdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read, one of each per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/pdc_matcher.sv]
// Table search engine: walks stored patterns leaf by leaf through the store RAM.
// Depends on pdc_pkg for the search status struct.
module pdc_matcher #(
  parameter int ENT_W      = 8,
  parameter int IDX_W      = 4,
  parameter int LEAF_CNT_W = 5,
  parameter int LEAF_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [LEAF_CNT_W-1:0] need,
  input  logic [ENT_W:0]        in_use,
  input  logic [LEAF_BITS-1:0]  rd_leaf,
  input  logic [LEAF_BITS-1:0]  ref_leaf,
  output logic [ENT_W+IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0]      ref_idx,
  output pdc_pkg::match_stat_t  stat,
  output logic [ENT_W-1:0]      hit_ent
);
  import pdc_pkg::*;

  // Issue side: entry and leaf of the read being launched.
  logic             busy;
  logic [ENT_W:0]   iss_ent;
  logic [IDX_W-1:0] iss_idx;

  // Compare side: the read whose data arrives this cycle.
  logic                 pend;
  logic [ENT_W-1:0]     pend_ent;
  logic                 pend_last;
  logic [LEAF_BITS-1:0] pend_ref;

  logic issue_en;
  logic idx_last;
  logic eq;
  logic hit;
  logic miss;
  logic abort;

  // A read is launched every cycle while entries remain; a mismatch restarts
  // the walk at the next entry and drops the read launched behind it.
  always_comb begin
    issue_en = busy && (iss_ent < in_use);
    idx_last = (LEAF_CNT_W'(iss_idx) == (need - LEAF_CNT_W'(1)));
    eq       = (rd_leaf == pend_ref);
    hit      = busy && pend && eq && pend_last;
    abort    = busy && pend && !eq;
    miss     = busy && !pend && !issue_en;
    stat.done = hit || miss;
    stat.hit  = hit;
  end

  assign rd_addr = {iss_ent[ENT_W-1:0], iss_idx};
  assign ref_idx = iss_idx;
  assign hit_ent = pend_ent;

  // Walk sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      pend    <= 1'b0;
      iss_ent <= '0;
      iss_idx <= '0;
    end else if (busy) begin
      if (hit || miss) begin
        busy <= 1'b0;
        pend <= 1'b0;
      end else if (abort) begin
        pend    <= 1'b0;
        iss_ent <= {1'b0, pend_ent} + (ENT_W+1)'(1);
        iss_idx <= '0;
      end else begin
        pend <= issue_en;
        if (issue_en) begin
          pend_ent  <= iss_ent[ENT_W-1:0];
          pend_last <= idx_last;
          pend_ref  <= ref_leaf;
          if (idx_last) begin
            iss_ent <= iss_ent + (ENT_W+1)'(1);
            iss_idx <= '0;
          end else begin
            iss_idx <= iss_idx + IDX_W'(1);
          end
        end
      end
    end
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench for pattern_dedup_counter_core: random and directed patterns.
// Needs pdc_pkg and the core RTL. A table model inside a scoreboard class predicts each result.
`timescale 1ns / 1ps

// Scoreboard: keeps its own pattern table and predicts the result of every pattern.
class pattern_tally;
  localparam int ENTRIES = pdc_pkg::MAX_PATTERNS_DEF;
  localparam int SIDE_MAX = pdc_pkg::MAX_SIDE_DEF;
  localparam int LEAVES = SIDE_MAX * SIDE_MAX;

  bit [31:0] stored [ENTRIES][LEAVES];
  bit [31:0] counts [ENTRIES];
  bit [31:0] incoming [LEAVES];
  int in_use;
  int received;
  bit [pdc_pkg::SIDE_W-1:0] side_reg;
  pdc_pkg::result_item_t awaited[$];
  int errors;

  function new();
    side_reg = pdc_pkg::SIDE_RESET;
    in_use = 0;
    received = 0;
    errors = 0;
  endfunction

  function void write_side(bit [pdc_pkg::SIDE_W-1:0] value);
    side_reg = value;
  endfunction

  // Out-of-range sides are clamped into 2..SIDE_MAX.
  function int side_need();
    int side;
    side = side_reg;
    if (side < 2) side = 2;
    if (side > SIDE_MAX) side = SIDE_MAX;
    return side * side;
  endfunction

  // Note one accepted leaf; the last leaf of a pattern queues its expected result.
  function void take_leaf(pdc_pkg::leaf_item_t item);
    int need;
    int found;
    int e;
    int i;
    bit same;
    pdc_pkg::result_item_t want;
    need = side_need();
    if (received < LEAVES) incoming[received] = item.leaf;
    if (received < LEAVES + 1) received++;
    if (!item.last_leaf) return;
    want = '0;
    // A pattern of the wrong length leaves the table alone.
    if (received != need) begin
      received = 0;
      want.status = pdc_pkg::ST_LENGTH;
      awaited.push_back(want);
      return;
    end
    received = 0;
    // Search the table in order; the first exact match wins.
    found = -1;
    for (e = 0; e < in_use; e++) begin
      if (found < 0) begin
        same = 1'b1;
        for (i = 0; i < need; i++) begin
          if (stored[e][i] != incoming[i]) same = 1'b0;
        end
        if (same) found = e;
      end
    end
    if (found >= 0) begin
      if (counts[found] != 32'hFFFF_FFFF) counts[found]++;
      want.pattern_index = 8'(found);
      want.occurrences = counts[found];
      want.status = pdc_pkg::ST_OK;
    end else if (in_use >= ENTRIES) begin
      want.status = pdc_pkg::ST_FULL;
    end else begin
      for (i = 0; i < need; i++) stored[in_use][i] = incoming[i];
      counts[in_use] = 32'd1;
      want.pattern_index = 8'(in_use);
      want.is_new = 1'b1;
      want.occurrences = 32'd1;
      want.status = pdc_pkg::ST_OK;
      in_use++;
    end
    awaited.push_back(want);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Check one result transfer against the oldest expectation.
  function void check_result(pdc_pkg::result_item_t got);
    pdc_pkg::result_item_t want;
    if (awaited.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, got index %0d status %0d",
               $time, got.pattern_index, got.status);
      errors++;
      return;
    end
    want = awaited.pop_front();
    compare_field("pattern_index", 32'(want.pattern_index), 32'(got.pattern_index));
    compare_field("is_new", 32'(want.is_new), 32'(got.is_new));
    compare_field("occurrences", want.occurrences, got.occurrences);
    compare_field("status", 32'(want.status), 32'(got.status));
  endfunction
endclass

module testbench;
  import pdc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 32;
  localparam int HISTORY_DEPTH = 48;
  localparam int ROW = 24;
  localparam int TABLE_SIZE = MAX_PATTERNS_DEF;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RARE, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIDE_W-1:0] cfg_data = '0;
  logic leaf_valid = 1'b0;
  logic leaf_stall;
  leaf_item_t leaf_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_item_t result_data;

  pattern_tally tally = new();

  // Pattern being sent, and a ring of earlier well-formed patterns for repeats.
  bit [31:0] cur [ROW];
  bit [31:0] history [HISTORY_DEPTH][16];
  int hist_count = 0;
  int hist_next = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;

  pattern_dedup_counter_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .leaf_valid(leaf_valid),
    .leaf_stall(leaf_stall),
    .leaf_data(leaf_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result stall pattern: modes from never stalling to mostly stalled.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: result_stall <= 1'b0;
      STALL_COIN: result_stall <= 1'($urandom_range(0, 1));
      STALL_RARE: result_stall <= ($urandom_range(0, 7) == 0);
      default: result_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Monitor: check results first, then predict from the accepted leaf.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) tally.check_result(result_data);
      if (leaf_valid && !leaf_stall) tally.take_leaf(leaf_data);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (result_valid && !result_stall) || (leaf_valid && !leaf_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("pattern_dedup_counter_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bit [31:0] fresh_leaf();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF ^ 32'($urandom_range(0, 1));
      default: return $urandom;
    endcase
  endfunction

  // Send one leaf in bursts separated by random gaps.
  task automatic push_leaf(input bit [31:0] value, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        leaf_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    leaf_valid <= 1'b1;
    leaf_data <= '{leaf: value, last_leaf: last};
    do @(posedge clk); while (leaf_stall);
    burst_left--;
  endtask

  task automatic send_pattern(input int len);
    int i;
    for (i = 0; i < len; i++) push_leaf(cur[i], i == len - 1);
  endtask

  task automatic remember();
    int i;
    for (i = 0; i < 16; i++) history[hist_next][i] = cur[i];
    hist_next = (hist_next + 1) % HISTORY_DEPTH;
    if (hist_count < HISTORY_DEPTH) hist_count++;
  endtask

  task automatic recall();
    int src;
    int i;
    src = $urandom_range(0, hist_count - 1);
    for (i = 0; i < 16; i++) cur[i] = history[src][i];
  endtask

  // Build the next pattern: mostly repeats, near misses and fresh ones, some bad lengths.
  task automatic make_pattern(input int need, output int len);
    int pick;
    int pos;
    int i;
    pick = $urandom_range(0, 99);
    for (i = 0; i < ROW; i++) cur[i] = fresh_leaf();
    len = need;
    if (pick < 12) begin
      len = $urandom_range(1, need + 3);
      if (len == need) len = need + 1;
      if ($urandom_range(0, 3) == 0) len = $urandom_range(17, 22);
    end else if (pick < 50 && hist_count > 0) begin
      recall();
    end else if (pick < 65 && hist_count > 0) begin
      // Near miss: one bit off, usually in the final leaf.
      recall();
      pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, need - 1) : need - 1;
      cur[pos] = cur[pos] ^ (32'd1 << $urandom_range(0, 31));
    end
    if (len == need) remember();
  endtask

  // Let every expected result arrive, then give the block time to go quiet.
  // The first edge lets the monitor note the final leaf before the queue is polled.
  task automatic settle();
    leaf_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tally.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side_reg(input bit [SIDE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tally.write_side(value);
  endtask

  task automatic random_phase(input bit [SIDE_W-1:0] value, input int budget);
    int sent;
    int len;
    settle();
    write_side_reg(value);
    sent = 0;
    while (sent < budget) begin
      make_pattern(tally.side_need(), len);
      send_pattern(len);
      sent += len;
    end
  endtask

  // Fill the table at side 2, then probe it once it is full.
  task automatic fill_table();
    int serial;
    int len;
    int i;
    settle();
    write_side_reg(3'd0);
    serial = 0;
    while (tally.in_use < TABLE_SIZE) begin
      if (hist_count > 0 && $urandom_range(0, 4) == 0) begin
        recall();
      end else begin
        for (i = 0; i < ROW; i++) cur[i] = fresh_leaf();
        cur[0] = {8'hA5, 24'(serial)};
        serial++;
      end
      remember();
      send_pattern(4);
    end
    repeat (20) begin
      make_pattern(4, len);
      send_pattern(len);
    end
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: bad lengths at the reset side, a single leaf and an overlong run.
    cur[0] = 32'h0;
    send_pattern(1);
    for (k = 0; k < 18; k++) cur[k] = k[0] ? 32'hFFFF_FFFF : 32'h0;
    send_pattern(18);

    // The side only shrinks once entries exist, so stored leaves always cover a compare.
    random_phase(3'd7, 80);
    random_phase(3'd6, 60);
    random_phase(3'd5, 70);
    random_phase(3'd4, 60);
    random_phase(3'd3, 80);
    random_phase(3'd1, 70);
    random_phase(3'd2, 80);
    fill_table();

    settle();
    if (tally.errors == 0 && tally.awaited.size() == 0) begin
      $display("pattern_dedup_counter_core: match");
    end else begin
      if (tally.awaited.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, tally.awaited.size());
      $display("pattern_dedup_counter_core: mismatch");
    end
    $finish;
  end

endmodule
